>>> hw/rtl/sgm_pkg.sv
package sgm_pkg;

  localparam int POS_BITS = 24;
  localparam int GAP_BITS = 16;

  localparam int SAMPLE_BITS     = 16;
  localparam int MAG_BITS        = SAMPLE_BITS + 1;
  localparam int THRESH_BITS     = 15;
  localparam int MIN_GAP_BITS    = 16;
  localparam int LEAD_BITS       = 16;
  localparam int CLIP_BITS       = 24;
  localparam int MARKER_POS_BITS = 24;

  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 24;

  localparam int WIN_BITS     = ((POS_BITS > CLIP_BITS) ? POS_BITS : CLIP_BITS) + 1;
  localparam int GAP_CMP_BITS = (GAP_BITS > MIN_GAP_BITS) ? GAP_BITS : MIN_GAP_BITS;

  localparam logic [THRESH_BITS-1:0]  LEVEL_THRESHOLD_RST = THRESH_BITS'(33);
  localparam logic [MIN_GAP_BITS-1:0] MIN_GAP_RST         = MIN_GAP_BITS'(15000);
  localparam logic [LEAD_BITS-1:0]    LEAD_OFFSET_RST     = LEAD_BITS'(12000);
  localparam logic [CLIP_BITS-1:0]    CLIP_LENGTH_RST     = '0;

  localparam logic [CFG_ADDR_BITS-1:0] REG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_GAP         = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LEAD_OFFSET     = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CLIP_LENGTH     = 2'd3;

  localparam logic KIND_MARK_IN  = 1'b0;
  localparam logic KIND_MARK_OUT = 1'b1;

  typedef struct packed {
    logic [THRESH_BITS-1:0]  level_threshold;
    logic [MIN_GAP_BITS-1:0] min_gap;
    logic [LEAD_BITS-1:0]    lead_offset;
    logic [CLIP_BITS-1:0]    clip_length;
  } cfg_t;

  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
  } item_t;

  typedef struct packed {
    logic                       valid;
    logic                       kind;
    logic [MARKER_POS_BITS-1:0] position;
  } marker_t;

endpackage

>>> hw/rtl/sgm_if.sv
interface sgm_in_if;
  import sgm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first;

  modport source (output valid, output sample, output first, input ready);
  modport sink (input valid, input sample, input first, output ready);
endinterface

interface sgm_out_if;
  import sgm_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       marker_kind;
  logic [MARKER_POS_BITS-1:0] marker_position;

  modport source (output valid, output marker_kind, output marker_position, input ready);
  modport sink (input valid, input marker_kind, input marker_position, output ready);
endinterface

>>> hw/rtl/sgm_cfg_regs.sv
module sgm_cfg_regs
  import sgm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     we_i,
  input  logic [CFG_ADDR_BITS-1:0] addr_i,
  input  logic [CFG_DATA_BITS-1:0] wdata_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (addr_i)
        REG_LEVEL_THRESHOLD: cfg_d.level_threshold = wdata_i[THRESH_BITS-1:0];
        REG_MIN_GAP:         cfg_d.min_gap = wdata_i[MIN_GAP_BITS-1:0];
        REG_LEAD_OFFSET:     cfg_d.lead_offset = wdata_i[LEAD_BITS-1:0];
        REG_CLIP_LENGTH:     cfg_d.clip_length = wdata_i[CLIP_BITS-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold <= LEVEL_THRESHOLD_RST;
      cfg_q.min_gap         <= MIN_GAP_RST;
      cfg_q.lead_offset     <= LEAD_OFFSET_RST;
      cfg_q.clip_length     <= CLIP_LENGTH_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/sgm_in_stage.sv
module sgm_in_stage
  import sgm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  sgm_in_if.sink   in_i,
  input  logic     advance_i,
  output item_t    item_o
);

  logic                          valid_q, valid_d;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          first_q;
  logic                          accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_i.sample;
      first_q  <= in_i.first;
    end
  end

  assign item_o.valid  = valid_q;
  assign item_o.sample = sample_q;
  assign item_o.first  = first_q;

endmodule

>>> hw/rtl/sgm_core.sv
module sgm_core
  import sgm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  item_t   item_i,
  input  logic    advance_i,
  output marker_t marker_o
);

  logic [POS_BITS-1:0] position_q, position_d;
  logic                prev_speech_q, prev_speech_d;
  logic [GAP_BITS-1:0] silence_run_q, silence_run_d;
  logic                run_after_q, run_after_d;
  logic [POS_BITS-1:0] run_start_q, run_start_d;
  logic                gap_conf_q, gap_conf_d;

  logic [MAG_BITS-1:0] mag;
  logic                speech;
  logic [POS_BITS-1:0] p;
  logic                prev_eff, run_after_eff, gap_conf_eff;
  logic [GAP_BITS-1:0] run_eff;
  logic [POS_BITS-1:0] run_start_eff;
  logic [POS_BITS-1:0] win_pos;
  logic [WIN_BITS-1:0] win_sum;
  logic                in_window;
  logic                lead_ok;
  logic                gap_hit;

  assign mag = item_i.sample[SAMPLE_BITS-1]
             ? (MAG_BITS'(1) << SAMPLE_BITS) - {1'b0, item_i.sample}
             : {1'b0, item_i.sample};
  assign speech = mag > MAG_BITS'(cfg_i.level_threshold);

  // A first flag restarts the clip before this sample is handled.
  assign p             = item_i.first ? '0 : position_q;
  assign prev_eff      = item_i.first ? 1'b0 : prev_speech_q;
  assign run_after_eff = item_i.first ? 1'b0 : run_after_q;
  assign gap_conf_eff  = item_i.first ? 1'b0 : gap_conf_q;
  assign run_eff       = item_i.first ? '0 : silence_run_q;
  assign run_start_eff = item_i.first ? '0 : run_start_q;

  assign lead_ok   = p >= POS_BITS'(cfg_i.lead_offset);

  always_comb begin
    silence_run_d  = run_eff;
    run_after_d    = run_after_eff;
    run_start_d    = run_start_eff;
    gap_conf_d     = gap_conf_eff;
    win_pos        = p;
    win_sum        = WIN_BITS'(win_pos) + WIN_BITS'(cfg_i.min_gap);
    in_window      = (win_pos != '0) && (win_sum < WIN_BITS'(cfg_i.clip_length));
    gap_hit        = 1'b0;
    marker_o.valid = 1'b0;
    marker_o.kind  = KIND_MARK_IN;
    marker_o.position = MARKER_POS_BITS'(p - POS_BITS'(cfg_i.lead_offset));

    if (speech) begin
      if (!prev_eff && !(run_after_eff && !gap_conf_eff) && in_window && lead_ok) begin
        marker_o.valid = item_i.valid;
      end
      silence_run_d = '0;
      run_after_d   = 1'b0;
      gap_conf_d    = 1'b0;
    end else begin
      if (prev_eff) begin
        run_after_d   = 1'b1;
        run_start_d   = p;
        silence_run_d = '0;
        gap_conf_d    = 1'b0;
      end
      if (!(&silence_run_d)) begin
        silence_run_d = silence_run_d + GAP_BITS'(1);
      end
      gap_hit   = GAP_CMP_BITS'(silence_run_d) >= GAP_CMP_BITS'(cfg_i.min_gap);
      win_pos   = run_start_d;
      win_sum   = WIN_BITS'(win_pos) + WIN_BITS'(cfg_i.min_gap);
      in_window = (win_pos != '0) && (win_sum < WIN_BITS'(cfg_i.clip_length));
      marker_o.kind     = KIND_MARK_OUT;
      marker_o.position = MARKER_POS_BITS'(run_start_d);
      if (run_after_d && !gap_conf_d && gap_hit) begin
        gap_conf_d = 1'b1;
        if (in_window) begin
          marker_o.valid = item_i.valid;
        end
      end
    end

    prev_speech_d = speech;
    position_d    = (&p) ? p : p + POS_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q    <= '0;
      prev_speech_q <= 1'b0;
      silence_run_q <= '0;
      run_after_q   <= 1'b0;
      run_start_q   <= '0;
      gap_conf_q    <= 1'b0;
    end else if (advance_i) begin
      position_q    <= position_d;
      prev_speech_q <= prev_speech_d;
      silence_run_q <= silence_run_d;
      run_after_q   <= run_after_d;
      run_start_q   <= run_start_d;
      gap_conf_q    <= gap_conf_d;
    end
  end

endmodule

>>> hw/rtl/speech_gap_marker_detector.sv
// Speech gap marker detector.
// Samples enter on in_i, one request per sample, with a first flag that
// starts a new clip. Markers leave on out_o: a mark-in at a speech onset
// less the lead offset, or a mark-out at the start of a long pause.
// Most samples produce no marker and are absorbed without output.
// Configuration is written through cfg_we_i, cfg_addr_i and cfg_wdata_i;
// the user must write it only while no request is in flight, which the
// block does not enforce. A write takes effect on the next cycle. A sample
// is registered on acceptance and evaluated once the output register is
// free or taken, so its marker is loaded into the output register and is
// then valid on out_o. One sample per cycle is sustained while out_o is
// not stalled; the input and output registers each hold one request.
// When the receiver stalls with a marker pending, one more sample may wait
// in the input register, after which in_i.ready drops until out_o is taken.
// Reset clears the clip position, the run state and both registers, and
// loads the default threshold, gap and lead offset with a clip length of 0.
module speech_gap_marker_detector
  import sgm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  sgm_in_if.sink                   in_i,
  sgm_out_if.source                out_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   item;
  marker_t marker;
  logic    advance;

  logic                       out_valid_q, out_valid_d;
  logic                       out_kind_q;
  logic [MARKER_POS_BITS-1:0] out_pos_q;

  sgm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  sgm_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .item_o    (item)
  );

  sgm_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item),
    .advance_i (advance),
    .marker_o  (marker)
  );

  assign advance = item.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && marker.valid) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && marker.valid) begin
      out_kind_q <= marker.kind;
      out_pos_q  <= marker.position;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.marker_kind     = out_kind_q;
  assign out_o.marker_position = out_pos_q;

`ifndef NO_ASSERTIONS
  a_marker_from_advance: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance)
  ) else $error("marker appeared without an evaluated sample");

  a_no_advance_on_stall: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !advance
  ) else $error("sample evaluated while the output register was blocked");

  a_ready_only_when_free: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (item.valid && !advance)
  ) else $error("input held off with a free input register");
`endif

endmodule

>>> tb/tb_speech_gap_marker_detector.sv
module tb_speech_gap_marker_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import sgm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          first;
  } sample_req_t;

  typedef struct packed {
    logic                       kind;
    logic [MARKER_POS_BITS-1:0] pos;
  } marker_exp_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_ADDR_BITS-1:0] cfg_addr_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;

  sgm_in_if  in_bus ();
  sgm_out_if out_bus ();

  speech_gap_marker_detector i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  sample_req_t sample_q[$];
  marker_exp_t marker_q[$];

  logic [THRESH_BITS-1:0]  thr_r  = LEVEL_THRESHOLD_RST;
  logic [MIN_GAP_BITS-1:0] gap_r  = MIN_GAP_RST;
  logic [LEAD_BITS-1:0]    lead_r = LEAD_OFFSET_RST;
  logic [CLIP_BITS-1:0]    clip_r = CLIP_LENGTH_RST;

  logic [POS_BITS-1:0] pos_cnt            = '0;
  logic                was_speech         = 1'b0;
  logic [GAP_BITS-1:0] quiet_len          = '0;
  logic                quiet_after_speech = 1'b0;
  logic [POS_BITS-1:0] quiet_start        = '0;
  logic                pause_marked       = 1'b0;

  int  errors = 0;
  int  pushed = 0;
  int  taken = 0;
  int  mark_in_seen = 0;
  int  mark_out_seen = 0;
  int  settings = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  int  choke_left = 0;
  bit  choke_arm = 1'b0;
  bit  choke_done = 1'b0;
  bit  calm = 1'b0;

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic logic in_window(logic [POS_BITS-1:0] q);
    return (q != '0) && ({8'h00, q} + {16'h0000, gap_r} < {8'h00, clip_r});
  endfunction

  function automatic void note_marker(logic kind, logic [MARKER_POS_BITS-1:0] pos);
    marker_exp_t m;
    m.kind = kind;
    m.pos  = pos;
    marker_q.insert(marker_q.size(), m);
  endfunction

  function automatic void predict_marker(sample_req_t r);
    logic [MAG_BITS-1:0] mag;
    logic                talk;
    logic                bridged;
    logic [POS_BITS-1:0] at;
    mag = r.sample[SAMPLE_BITS-1] ? (17'h10000 - {1'b0, r.sample}) : {1'b0, r.sample};
    talk = mag > {2'b00, thr_r};
    if (r.first) begin
      pos_cnt = '0;
      was_speech = 1'b0;
      quiet_len = '0;
      quiet_after_speech = 1'b0;
      quiet_start = '0;
      pause_marked = 1'b0;
    end
    at = pos_cnt;
    if (talk) begin
      bridged = quiet_after_speech && !pause_marked;
      if (!was_speech && !bridged && in_window(at) && at >= {8'h00, lead_r}) begin
        note_marker(KIND_MARK_IN, at - {8'h00, lead_r});
      end
      quiet_len = '0;
      quiet_after_speech = 1'b0;
      pause_marked = 1'b0;
    end else begin
      if (was_speech) begin
        quiet_after_speech = 1'b1;
        quiet_start = at;
        quiet_len = '0;
        pause_marked = 1'b0;
      end
      if (quiet_len != '1) quiet_len++;
      if (quiet_after_speech && !pause_marked && quiet_len >= gap_r) begin
        pause_marked = 1'b1;
        if (in_window(quiet_start)) note_marker(KIND_MARK_OUT, quiet_start);
      end
    end
    was_speech = talk;
    if (pos_cnt != '1) pos_cnt++;
  endfunction

  task automatic check_marker(logic kind, logic [MARKER_POS_BITS-1:0] pos);
    marker_exp_t want;
    if (marker_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected marker kind %0d at %0d", kind, pos));
      return;
    end
    want = marker_q.pop_front();
    if (kind !== want.kind) begin
      flag_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
    end
    if (pos !== want.pos) begin
      flag_mismatch($sformatf("position %0d, expected %0d", pos, want.pos));
    end
    if (want.kind == KIND_MARK_IN) mark_in_seen++;
    else mark_out_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic nxt_valid;
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.sample <= '0;
      in_bus.first <= 1'b0;
      gap_left <= 0;
    end else begin
      nxt_valid = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        predict_marker(sample_q.pop_front());
        taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (!calm && sample_q.size() != 0 && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 7);
        end else if (sample_q.size() != 0) begin
          nxt_valid = 1'b1;
          in_bus.sample <= sample_q[0].sample;
          in_bus.first <= sample_q[0].first;
        end
      end
      in_bus.valid <= nxt_valid;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic rdy;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_marker(out_bus.marker_kind, out_bus.marker_position);
      end
      rdy = 1'b1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold_left <= $urandom_range(0, 7);
        rdy = 1'b0;
      end
      if (choke_left != 0) rdy = 1'b0;
      out_bus.ready <= rdy;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      choke_left <= 0;
      choke_done <= 1'b0;
    end else if (choke_arm && !choke_done) begin
      choke_left <= 200;
      choke_done <= 1'b1;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("FAIL speech_gap_marker_detector");
    $finish;
  end

  task automatic cfg_write(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_LEVEL_THRESHOLD: thr_r = val[THRESH_BITS-1:0];
      REG_MIN_GAP:         gap_r = val[MIN_GAP_BITS-1:0];
      REG_LEAD_OFFSET:     lead_r = val[LEAD_BITS-1:0];
      REG_CLIP_LENGTH:     clip_r = val[CLIP_BITS-1:0];
      default:             ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sample_q.size() != 0 || in_bus.valid || marker_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_regs(int thr, int gap, int lead, int clip);
    wait_drained();
    cfg_write(REG_LEVEL_THRESHOLD, CFG_DATA_BITS'(thr));
    cfg_write(REG_MIN_GAP, CFG_DATA_BITS'(gap));
    cfg_write(REG_LEAD_OFFSET, CFG_DATA_BITS'(lead));
    cfg_write(REG_CLIP_LENGTH, CFG_DATA_BITS'(clip));
    @(negedge clk_i);
    settings++;
  endtask

  task automatic push_sample(logic [SAMPLE_BITS-1:0] s, logic f);
    sample_req_t r;
    r.sample = s;
    r.first  = f;
    sample_q.insert(sample_q.size(), r);
    pushed++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] loud_sample();
    int m;
    m = $urandom_range(int'(thr_r) + 1, 32768);
    if (m == 32768 || $urandom_range(0, 1) == 1) return SAMPLE_BITS'(-m);
    return SAMPLE_BITS'(m);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] quiet_sample();
    int m;
    m = $urandom_range(0, int'(thr_r));
    if ($urandom_range(0, 1) == 1) return SAMPLE_BITS'(-m);
    return SAMPLE_BITS'(m);
  endfunction

  task automatic add_clip(int len);
    int  n;
    int  seg;
    bit  talk;
    logic [SAMPLE_BITS-1:0] s;
    n = 0;
    talk = $urandom_range(0, 1);
    while (n < len) begin
      if (talk) seg = $urandom_range(1, 6);
      else if ($urandom_range(0, 3) == 0) seg = int'(gap_r) + $urandom_range(0, 3);
      else seg = $urandom_range(1, int'(gap_r) + 1);
      if (seg > 70) seg = $urandom_range(1, 70);
      for (int k = 0; k < seg && n < len; k++) begin
        if ($urandom_range(0, 11) == 0) s = SAMPLE_BITS'($urandom);
        else s = talk ? loud_sample() : quiet_sample();
        push_sample(s, (n == 0 && $urandom_range(0, 15) != 0) || $urandom_range(0, 79) == 0);
        n++;
      end
      talk = !talk;
    end
  endtask

  task automatic add_random(int items);
    int goal;
    goal = pushed + items;
    while (pushed < goal) add_clip($urandom_range(5, 60));
  endtask

  initial begin
    int dir_s [18] = '{32767, 0, -32768, 100, -100, 0, -1, 101, -101, 5, 32767,
                       0, -50, 100, -32768, 1, 2, 32767};
    int gap;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    add_random(40);

    set_regs(100, 3, 2, 40);
    for (int k = 0; k < 18; k++) push_sample(SAMPLE_BITS'(dir_s[k]), k == 0 || k == 11);

    set_regs(0, 0, 0, 24'hFFFFFF);
    add_random(150);

    set_regs(32767, 65535, 65535, 24'hFFFFFF);
    add_random(80);

    set_regs(33, 4, 3, 5);
    add_random(60);

    set_regs(500, 0, 0, 24'hFFFFFF);
    for (int k = 0; k < 300; k++) begin
      push_sample((k % 2 == 0) ? loud_sample() : quiet_sample(), k == 0);
    end
    @(posedge clk_i);
    choke_arm <= 1'b1;

    repeat (4) begin
      gap = $urandom_range(0, 12);
      set_regs(($urandom_range(0, 4) == 0) ? $urandom_range(4000, 32767) : $urandom_range(0, 4000),
               gap, $urandom_range(0, 12),
               ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom_range(gap + 2, 120));
      add_random(200);
    end

    set_regs($urandom_range(0, 2000), 5, 4, 200);
    calm = 1'b1;
    add_random(250);

    wait_drained();
    repeat (6) @(negedge clk_i);
    $display("%0d samples accepted under %0d register settings", taken, settings);
    $display("%0d mark-in and %0d mark-out markers checked, %0d mismatches",
             mark_in_seen, mark_out_seen, errors);
    if (errors == 0) begin
      $display("PASS speech_gap_marker_detector");
    end else begin
      $display("FAIL speech_gap_marker_detector");
    end
    $finish;
  end

endmodule

>>> speech_gap_marker_detector.f
hw/rtl/sgm_pkg.sv
hw/rtl/sgm_if.sv
hw/rtl/sgm_cfg_regs.sv
hw/rtl/sgm_in_stage.sv
hw/rtl/sgm_core.sv
hw/rtl/speech_gap_marker_detector.sv
tb/tb_speech_gap_marker_detector.sv
